// ===== rtl/core/srpr_pkg.sv =====
// package for the snap ring packet receiver core
// receive phases, result kinds, header constants, crc-8 step and the result frame type
// no dependencies
package srpr_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'h54;
  localparam logic [7:0] HDB2_MASK   = 8'hfc;
  localparam logic [7:0] HDB2_FORMAT = 8'h50;
  localparam logic [3:0] HDB1_FORMAT = 4'h3;
  localparam logic [7:0] HDB1_REPLY  = 8'h30;
  localparam logic [7:0] HDB2_ACK    = 8'h52;
  localparam logic [7:0] HDB2_NAK    = 8'h53;
  localparam logic [1:0] ACK_REQUEST = 2'd1;

  localparam int FRAME_SLOTS = 6;
  localparam int LEN_W       = 11;
  localparam int INDEX_W     = 10;
  localparam int TDATA_W     = 32;

  localparam logic [7:0][7:0] CRC_BITS = {
    8'h8c, 8'h46, 8'h23, 8'h9d, 8'hc2, 8'h61, 8'hbc, 8'h5e
  };

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_SYNC      = 4'd1,
    PH_HDB2      = 4'd2,
    PH_HDB1      = 4'd3,
    PH_DAB       = 4'd4,
    PH_DATA      = 4'd5,
    PH_CRC       = 4'd6,
    PH_HDB2_PASS = 4'd7,
    PH_HDB1_PASS = 4'd8,
    PH_DAB_PASS  = 4'd9,
    PH_DATA_PASS = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef struct packed {
    logic [2:0]                           count;
    logic [FRAME_SLOTS-1:0][1:0]          kind;
    logic [FRAME_SLOTS-1:0][7:0]          value;
    logic [FRAME_SLOTS-1:0][INDEX_W-1:0]  index;
    logic                                 pending;
    logic [7:0]                           reply;
  } frame_t;

  function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] r;
    x = crc ^ b;
    r = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (x[k]) begin
        r = r ^ CRC_BITS[k];
      end
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] decode_length(input logic [7:0] hdb1);
    logic [LEN_W-1:0] len;
    if (hdb1[3]) begin
      len = LEN_W'(11'd8 << hdb1[2:0]);
    end else begin
      len = LEN_W'(hdb1[3:0]);
    end
    return len;
  endfunction

endpackage

// ===== rtl/core/snap_ring_packet_receiver_core.sv =====
// top level of the snap ring packet receiver: input register, frame register, output sequencer
// depends on srpr_pkg and srpr_parse
//
//   channel  | direction | fields (tdata/tuser low bit up)
//   s_*      | in        | tuser: action; tdata: rx_byte
//   m_*      | out       | tuser: kind; tdata: value, payload_index, packet_pending,
//            |           |   reply_address; tlast: last
//   cfg_*    | in        | cfg_data: device_address, written when cfg_write is high
//
// each item gives 1 to 7 results, one per cycle from the frame register while m_tready is
// high; each item holds m_* to its last result, so the output sequencer sets the rate.
// first result is on m_* once the frame register loads the item from the input register.
// rst is synchronous: lock cleared, receiver idle, device_address zero.
// while a frame waits on m_tready the input register holds one more item, then s_tready drops.
module snap_ring_packet_receiver_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // rx_byte
  input  logic                         s_tuser,   // action
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [srpr_pkg::TDATA_W-1:0] m_tdata,   // value, payload_index, packet_pending,
                                                  // reply_address, zero fill
  output logic [1:0]                   m_tuser,   // kind
  output logic                         m_tlast,   // last
  input  logic                         cfg_write,
  input  logic [7:0]                   cfg_data
);
  import srpr_pkg::*;

  logic              in_valid;
  logic              in_action;
  logic [7:0]        in_byte;
  logic [7:0]        device_address;
  logic              load;
  logic              frame_valid;
  frame_t            frame_q;
  frame_t            frame_d;
  logic [2:0]        ptr;
  logic              at_status;
  logic              done;
  logic [1:0]        out_kind;
  logic [7:0]        out_value;
  logic [INDEX_W-1:0] out_index;

  srpr_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .step           (load),
    .action         (in_action),
    .rx_byte        (in_byte),
    .device_address (device_address),
    .frame          (frame_d)
  );

  assign at_status = (ptr == frame_q.count);
  assign done      = frame_valid && m_tready && at_status;
  assign load      = in_valid && (!frame_valid || done);
  assign s_tready  = !in_valid || load;

  always_comb begin
    if (at_status) begin
      out_kind  = KIND_STATUS;
      out_value = 8'h00;
      out_index = '0;
    end else begin
      out_kind  = frame_q.kind[ptr];
      out_value = frame_q.value[ptr];
      out_index = frame_q.index[ptr];
    end
  end

  assign m_tvalid = frame_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = at_status;
  assign m_tdata  = {5'b0, frame_q.reply, frame_q.pending, out_index, out_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= '0;
    end else if (cfg_write) begin
      device_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_byte   <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      ptr         <= '0;
    end else if (load) begin
      frame_valid <= 1'b1;
      ptr         <= '0;
    end else if (done) begin
      frame_valid <= 1'b0;
      ptr         <= '0;
    end else if (frame_valid && m_tready) begin
      ptr <= ptr + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_q <= frame_d;
    end
  end

endmodule

// ===== rtl/core/srpr_parse.sv =====
// protocol state and per-item decode of the snap ring packet receiver
// builds the whole result frame for one item combinationally; uses srpr_pkg
module srpr_parse (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           action,
  input  logic [7:0]     rx_byte,
  input  logic [7:0]     device_address,
  output srpr_pkg::frame_t frame
);
  import srpr_pkg::*;

  phase_t             phase, phase_next;
  logic [7:0]         header_two, header_two_next;
  logic [7:0]         header_one, header_one_next;
  logic [LEN_W-1:0]   length_left, length_left_next;
  logic [7:0]         source_seen, source_seen_next;
  logic [7:0]         saved_reply, saved_reply_next;
  logic [LEN_W-1:0]   write_index, write_index_next;
  logic [7:0]         running_crc, running_crc_next;
  logic               lock_flag, lock_flag_next;
  logic               ack_wanted, ack_wanted_next;

  logic               crc_match;
  logic [7:0]         ack_hdb2;
  logic [7:0]         fc1, fc2, fc3, fc4;
  logic [7:0]         crc_in;
  logic [LEN_W-1:0]   index_inc;

  assign crc_in    = crc_next(running_crc, rx_byte);
  assign index_inc = write_index + LEN_W'(1);
  assign crc_match = (rx_byte == running_crc) && !lock_flag;
  assign ack_hdb2  = crc_match ? HDB2_ACK : HDB2_NAK;
  assign fc1       = crc_next(8'h00, ack_hdb2);
  assign fc2       = crc_next(fc1, HDB1_REPLY);
  assign fc3       = crc_next(fc2, source_seen);
  assign fc4       = crc_next(fc3, device_address);

  // next state
  always_comb begin
    phase_next       = phase;
    header_two_next  = header_two;
    header_one_next  = header_one;
    length_left_next = length_left;
    source_seen_next = source_seen;
    saved_reply_next = saved_reply;
    write_index_next = write_index;
    running_crc_next = running_crc;
    lock_flag_next   = lock_flag;
    ack_wanted_next  = ack_wanted;
    if (action) begin
      lock_flag_next = 1'b0;
    end else begin
      case (phase)
        PH_SYNC: begin
          header_two_next = rx_byte;
          if ((rx_byte & HDB2_MASK) != HDB2_FORMAT) begin
            phase_next = PH_HDB2_PASS;
          end else begin
            ack_wanted_next  = (rx_byte[1:0] == ACK_REQUEST);
            running_crc_next = crc_next(8'h00, rx_byte);
            phase_next       = PH_HDB2;
          end
        end
        PH_HDB2: begin
          header_one_next  = rx_byte;
          length_left_next = decode_length(rx_byte);
          if (rx_byte[7:4] != HDB1_FORMAT) begin
            phase_next = PH_HDB1_PASS;
          end else begin
            running_crc_next = crc_in;
            phase_next       = PH_HDB1;
          end
        end
        PH_HDB1: begin
          if (rx_byte != device_address) begin
            phase_next = PH_DAB_PASS;
          end else begin
            running_crc_next = crc_in;
            phase_next       = PH_DAB;
          end
        end
        PH_DAB: begin
          source_seen_next = rx_byte;
          write_index_next = '0;
          running_crc_next = crc_in;
          phase_next       = (length_left == '0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          write_index_next = index_inc;
          running_crc_next = crc_in;
          if (index_inc == length_left) begin
            phase_next = PH_CRC;
          end
        end
        PH_CRC: begin
          if (crc_match) begin
            lock_flag_next   = 1'b1;
            saved_reply_next = source_seen;
          end
          if (ack_wanted) begin
            running_crc_next = fc4;
          end
          phase_next = PH_IDLE;
        end
        PH_HDB2_PASS: begin
          header_one_next  = rx_byte;
          length_left_next = decode_length(rx_byte);
          phase_next       = PH_HDB1_PASS;
        end
        PH_HDB1_PASS: begin
          phase_next = PH_DAB_PASS;
        end
        PH_DAB_PASS: begin
          length_left_next = length_left + LEN_W'(1);
          phase_next       = PH_DATA_PASS;
        end
        PH_DATA_PASS: begin
          if (length_left > LEN_W'(1)) begin
            length_left_next = length_left - LEN_W'(1);
          end else begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = (rx_byte == SYNC_BYTE) ? PH_SYNC : PH_IDLE;
        end
      endcase
    end
  end

  // result frame
  always_comb begin
    frame         = '0;
    frame.pending = lock_flag_next;
    frame.reply   = saved_reply_next;
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      frame.kind[i] = KIND_TX;
    end
    if (!action) begin
      case (phase)
        PH_SYNC: begin
          if ((rx_byte & HDB2_MASK) != HDB2_FORMAT) begin
            frame.count    = 3'd2;
            frame.value[0] = SYNC_BYTE;
            frame.value[1] = rx_byte;
          end
        end
        PH_HDB2: begin
          if (rx_byte[7:4] != HDB1_FORMAT) begin
            frame.count    = 3'd3;
            frame.value[0] = SYNC_BYTE;
            frame.value[1] = header_two;
            frame.value[2] = rx_byte;
          end
        end
        PH_HDB1: begin
          if (rx_byte != device_address) begin
            frame.count    = 3'd4;
            frame.value[0] = SYNC_BYTE;
            frame.value[1] = header_two;
            frame.value[2] = header_one;
            frame.value[3] = rx_byte;
          end
        end
        PH_DATA: begin
          if (!lock_flag) begin
            frame.count    = 3'd1;
            frame.kind[0]  = KIND_WRITE;
            frame.value[0] = rx_byte;
            frame.index[0] = write_index[INDEX_W-1:0];
          end
        end
        PH_CRC: begin
          if (ack_wanted) begin
            frame.count    = 3'd6;
            frame.value[0] = SYNC_BYTE;
            frame.value[1] = ack_hdb2;
            frame.value[2] = HDB1_REPLY;
            frame.value[3] = source_seen;
            frame.value[4] = device_address;
            frame.value[5] = fc4;
          end
        end
        PH_HDB2_PASS, PH_HDB1_PASS, PH_DAB_PASS, PH_DATA_PASS: begin
          frame.count    = 3'd1;
          frame.value[0] = rx_byte;
        end
        default: begin
          frame.count = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      header_two  <= '0;
      header_one  <= '0;
      length_left <= '0;
      source_seen <= '0;
      saved_reply <= '0;
      write_index <= '0;
      running_crc <= '0;
      lock_flag   <= 1'b0;
      ack_wanted  <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      header_two  <= header_two_next;
      header_one  <= header_one_next;
      length_left <= length_left_next;
      source_seen <= source_seen_next;
      saved_reply <= saved_reply_next;
      write_index <= write_index_next;
      running_crc <= running_crc_next;
      lock_flag   <= lock_flag_next;
      ack_wanted  <= ack_wanted_next;
    end
  end

endmodule
